// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// clocked concurrent assertion helpers used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, quiet while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/cdq_pkg.sv -----
// ----------------------------------------------------------------------------
// cdq_pkg
// shared types and constants of the circular buffer deque
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int WIDTH_DEF = 32;

  localparam int CAP_W    = 5;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_CLEAR      = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  // per-cycle command broadcast to every cell of the row
  typedef struct packed {
    logic             add_head;
    logic             add_tail;
    logic             drop_head;
    logic [CAP_W-1:0] count;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- design/cdq_cell.sv -----
// ----------------------------------------------------------------------------
// cdq_cell
// one storage cell of the deque row; cell 0 holds the front element
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_cell #(
  parameter int INDEX = 0,
  parameter int WIDTH = cdq_pkg::WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire cdq_pkg::cell_ctl_t ctl,
  input  wire logic [WIDTH-1:0]  left_val,
  input  wire logic [WIDTH-1:0]  right_val,
  input  wire logic [WIDTH-1:0]  push_val,
  output logic      [WIDTH-1:0]  value,
  output logic      [WIDTH-1:0]  back_tap
);

  logic at_tail;
  logic is_last;

  // first free slot, and the slot holding the back element
  assign at_tail = (32'(ctl.count) == 32'(INDEX));
  assign is_last = (32'(ctl.count) == 32'(INDEX + 1));

  always_ff @(posedge clk) begin
    if (ctl.add_head) begin
      value <= left_val;
    end else if (ctl.drop_head) begin
      value <= right_val;
    end else if (ctl.add_tail && at_tail) begin
      value <= push_val;
    end
  end

  assign back_tap = is_last ? value : '0;

endmodule

`default_nettype wire

// ----- design/circular_buffer_deque.sv -----
// ----------------------------------------------------------------------------
// circular_buffer_deque
// double-ended queue kept in a row of shifting cells, front in cell 0
// ----------------------------------------------------------------------------
// result path: the cell row and count update at the accepting edge; the result
//   register then loads from them once it is empty or its result is being taken
// throughput: one item per cycle while m_tready is high; every operation is at
//   most a shift or write of the cell row plus a count update
// reset: capacity 16, queue empty, no result pending; cell contents are not
//   cleared and are never shown while not part of the queue
`default_nettype none

module circular_buffer_deque #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF,
  parameter int WIDTH = cdq_pkg::WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [((WIDTH+7)/8)*8-1:0]    s_tdata,  // value
  input  wire logic [cdq_pkg::OP_W-1:0]      s_tuser,  // operation
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [((2*WIDTH+cdq_pkg::CAP_W+7)/8)*8-1:0] m_tdata,
    // occupancy, front_value, back_value, zero fill
  output logic [cdq_pkg::STATUS_W:0]         m_tuser,  // status, is_empty
  input  wire logic                          cfg_we,
  input  wire logic [cdq_pkg::CAP_W-1:0]     cfg_data  // capacity
);

  localparam int CAP_W     = cdq_pkg::CAP_W;
  localparam int M_RAW_W   = CAP_W + 2 * WIDTH;
  localparam int M_TDATA_W = ((M_RAW_W + 7) / 8) * 8;
  localparam int CAP_LIMIT = (DEPTH > 31) ? 31 : DEPTH;
  localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(CAP_LIMIT);

  logic [CAP_W-1:0]         capacity;
  logic [CAP_W-1:0]         count;
  logic [CAP_W-1:0]         count_next;
  logic [CAP_W-1:0]         cap_eff;
  logic                     full;
  logic                     accept;
  logic                     load;
  logic                     pend;
  cdq_pkg::status_t         pend_status;
  cdq_pkg::status_t         status_next;
  cdq_pkg::cell_ctl_t       ctl;
  logic [WIDTH-1:0]         in_value;
  logic [WIDTH-1:0]         cell_val [DEPTH];
  logic [WIDTH-1:0]         left_val [DEPTH];
  logic [WIDTH-1:0]         right_val [DEPTH];
  logic [WIDTH-1:0]         back_tap [DEPTH];
  logic [WIDTH-1:0]         back_any;

  logic                     out_valid;
  cdq_pkg::status_t         out_status;
  logic [CAP_W-1:0]         out_occ;
  logic                     out_empty;
  logic [WIDTH-1:0]         out_front;
  logic [WIDTH-1:0]         out_back;

  assign in_value = s_tdata[WIDTH-1:0];
  assign load     = pend && (!out_valid || m_tready);
  assign s_tready = !pend || load;
  assign accept   = s_tvalid && s_tready;

  // zero acts as one, anything above the store acts as the store depth
  always_comb begin
    if (capacity == '0) begin
      cap_eff = CAP_W'(1);
    end else if (capacity > CAP_MAX) begin
      cap_eff = CAP_MAX;
    end else begin
      cap_eff = capacity;
    end
  end

  assign full = (count >= cap_eff);

  always_comb begin
    count_next    = count;
    status_next   = cdq_pkg::ST_DONE;
    ctl.add_head  = 1'b0;
    ctl.add_tail  = 1'b0;
    ctl.drop_head = 1'b0;
    ctl.count     = count;
    unique case (cdq_pkg::op_t'(s_tuser))
      cdq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          status_next = cdq_pkg::ST_OVERFLOW;
        end else begin
          ctl.add_head = accept;
          count_next   = count + CAP_W'(1);
        end
      end
      cdq_pkg::OP_PUSH_BACK: begin
        if (full) begin
          status_next = cdq_pkg::ST_OVERFLOW;
        end else begin
          ctl.add_tail = accept;
          count_next   = count + CAP_W'(1);
        end
      end
      cdq_pkg::OP_POP_FRONT: begin
        if (count == '0) begin
          status_next = cdq_pkg::ST_UNDERFLOW;
        end else begin
          ctl.drop_head = accept;
          count_next    = count - CAP_W'(1);
        end
      end
      cdq_pkg::OP_POP_BACK: begin
        // the back slot simply drops out of the counted range
        if (count == '0) begin
          status_next = cdq_pkg::ST_UNDERFLOW;
        end else begin
          count_next = count - CAP_W'(1);
        end
      end
      cdq_pkg::OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= cdq_pkg::CAP_RESET;
      count    <= '0;
      pend     <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_data;
        count    <= '0;
      end else if (accept) begin
        count <= count_next;
      end
      if (accept) begin
        pend <= 1'b1;
      end else if (load) begin
        pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status <= status_next;
    end
  end

  // row of cells, each shifting toward its neighbor on front operations
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_val[i] = in_value;
    end else begin : g_mid
      assign left_val[i] = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign right_val[i] = '0;
    end else begin : g_inner
      assign right_val[i] = cell_val[i+1];
    end

    cdq_cell #(
      .INDEX (i),
      .WIDTH (WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .left_val  (left_val[i]),
      .right_val (right_val[i]),
      .push_val  (in_value),
      .value     (cell_val[i]),
      .back_tap  (back_tap[i])
    );
  end

  // only the cell at the back drives a nonzero tap
  always_comb begin
    back_any = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_any = back_any | back_tap[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status <= pend_status;
      out_occ    <= count;
      out_empty  <= (count == '0);
      out_front  <= (count == '0) ? '0 : cell_val[0];
      out_back   <= back_any;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = M_TDATA_W'({out_back, out_front, out_occ});
  assign m_tuser  = {out_empty, out_status};

endmodule

`default_nettype wire

// ----- design/cdq_checker.sv -----
// ----------------------------------------------------------------------------
// cdq_checker
// port-level checks on the result stream of the deque
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cdq_checker #(
  parameter int WIDTH = cdq_pkg::WIDTH_DEF
) (
  input wire logic                                       clk,
  input wire logic                                       rst,
  input wire logic                                       m_tvalid,
  input wire logic                                       m_tready,
  input wire logic [((2*WIDTH+cdq_pkg::CAP_W+7)/8)*8-1:0] m_tdata,
  input wire logic [cdq_pkg::STATUS_W:0]                 m_tuser
);

  localparam int CAP_W = cdq_pkg::CAP_W;

  logic [CAP_W-1:0]             occ;
  logic [WIDTH-1:0]             front_v;
  logic [WIDTH-1:0]             back_v;
  logic [cdq_pkg::STATUS_W-1:0] status;
  logic                         empty;

  assign occ     = m_tdata[CAP_W-1:0];
  assign front_v = m_tdata[CAP_W+WIDTH-1:CAP_W];
  assign back_v  = m_tdata[CAP_W+2*WIDTH-1:CAP_W+WIDTH];
  assign status  = m_tuser[cdq_pkg::STATUS_W-1:0];
  assign empty   = m_tuser[cdq_pkg::STATUS_W];

  `ASSERT_CLK(a_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
  `ASSERT_CLK(a_empty_flag, clk, rst, m_tvalid |-> (empty == (occ == '0)), "empty flag disagrees with occupancy")
  `ASSERT_CLK(a_empty_zero, clk, rst, m_tvalid && empty |-> (front_v == '0) && (back_v == '0), "empty queue shows data")
  `ASSERT_CLK(a_status, clk, rst, m_tvalid |-> (status == cdq_pkg::ST_DONE) || (status == cdq_pkg::ST_UNDERFLOW) || (status == cdq_pkg::ST_OVERFLOW), "bad status code")
  `ASSERT_CLK(a_underflow, clk, rst, m_tvalid && (status == cdq_pkg::ST_UNDERFLOW) |-> empty, "underflow on a nonempty queue")

endmodule

bind circular_buffer_deque cdq_checker #(
  .WIDTH (WIDTH)
) u_cdq_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
